// ===== hw/rtl/vlmrq_pkg.sv =====
// Shared types, codes and defaults for the message ring queue.
package vlmrq_pkg;

  localparam int SLOTS_DEF     = 16;
  localparam int MAX_BYTES_DEF = 64;

  // Register reset values
  localparam logic [4:0] SLOTS_IN_USE_RST = 5'd16;
  localparam logic [6:0] MAX_BYTES_RST    = 7'd64;

  // Configuration register indexes
  localparam logic CFG_SLOTS_IN_USE = 1'b0;
  localparam logic CFG_MAX_BYTES    = 1'b1;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BAD_LEN = 3'd1,
    ST_FULL    = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_SMALL   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RX_LEN,
    S_RX_STREAM
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic accept_send;
    logic accept_rx;
    logic rx_fail_empty;
    logic rx_fail_small;
    logic rx_zero;
    logic rx_begin;
    logic rx_issue;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic empty;
    logic too_small;
    logic zero_len;
    logic stream_last;
  } dp_stat_t;

endpackage

// ===== hw/rtl/vlmrq_ctrl.sv =====
// Controller state machine: request acceptance and receive sequencing.
module vlmrq_ctrl
  import vlmrq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     operation,
  input  dp_stat_t stat,
  output cmd_t     cmd,
  output logic     busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (operation) begin
            cmd.accept_rx = 1'b1;
            state_next    = S_RX_LEN;
          end else begin
            cmd.accept_send = 1'b1;
          end
        end
      end
      S_RX_LEN: begin
        priority if (stat.empty) begin
          cmd.rx_fail_empty = 1'b1;
          state_next        = S_IDLE;
        end else if (stat.too_small) begin
          cmd.rx_fail_small = 1'b1;
          state_next        = S_IDLE;
        end else if (stat.zero_len) begin
          cmd.rx_zero = 1'b1;
          state_next  = S_IDLE;
        end else begin
          cmd.rx_begin = 1'b1;
          state_next   = S_RX_STREAM;
        end
      end
      S_RX_STREAM: begin
        cmd.rx_issue = 1'b1;
        if (stat.stream_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/vlmrq_dp.sv =====
// Datapath: config registers, slot memories, pointers, send tracking, result registers.
module vlmrq_dp
  import vlmrq_pkg::*;
#(
  parameter int SLOTS             = SLOTS_DEF,
  parameter int MAX_MESSAGE_BYTES = MAX_BYTES_DEF
)
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output dp_stat_t    stat,
  input  logic [7:0]  data_byte,
  input  logic [15:0] message_length,
  input  logic [15:0] destination_size,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  output logic        done,
  output logic [2:0]  status,
  output logic        is_receive,
  output logic [7:0]  out_byte,
  output logic [6:0]  received_length,
  output logic        last
);

  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW    = $clog2(SLOTS + 1);
  localparam int XW    = (CW > 5) ? CW : 5;
  localparam int NW    = SW + XW;
  localparam int DEPTH = SLOTS * MAX_MESSAGE_BYTES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Config
  logic [4:0] slots_in_use;
  logic [6:0] max_bytes;

  // Queue state
  logic [SW-1:0] head_slot, tail_slot;
  logic [CW-1:0] message_count;
  logic [15:0]   send_bytes_seen;
  logic [1:0]    send_verdict;

  // Memories
  logic [7:0] slot_bytes   [DEPTH];
  logic [6:0] slot_lengths [SLOTS];
  logic [6:0] len_rd;
  logic [7:0] byte_rd;

  // Receive working registers
  logic [AW-1:0] rx_base;
  logic [6:0]    rx_len;
  logic [6:0]    rx_idx;
  logic [15:0]   rx_dsz;

  // Result registers
  logic          r_valid;
  status_t       r_status;
  logic          r_is_rx;
  logic [6:0]    r_len;
  logic          r_last;
  logic          r_from_mem;

  // Effective register values
  logic [XW-1:0] eff_slots;
  logic [6:0]    eff_max;

  always_comb begin
    if (slots_in_use == 5'd0) begin
      eff_slots = XW'(1);
    end else if (XW'(slots_in_use) > XW'(SLOTS)) begin
      eff_slots = XW'(SLOTS);
    end else begin
      eff_slots = XW'(slots_in_use);
    end
    if (max_bytes == 7'd0) begin
      eff_max = 7'd1;
    end else if (max_bytes > 7'(MAX_MESSAGE_BYTES)) begin
      eff_max = 7'(MAX_MESSAGE_BYTES);
    end else begin
      eff_max = max_bytes;
    end
  end

  logic          is_full;
  logic [SW-1:0] tail_adv, head_adv;

  assign is_full = XW'(message_count) >= eff_slots;

  always_comb begin
    tail_adv = tail_slot + SW'(1);
    if ((NW'(tail_slot) + NW'(1)) >= NW'(eff_slots)) begin
      tail_adv = '0;
    end
    head_adv = head_slot + SW'(1);
    if ((NW'(head_slot) + NW'(1)) >= NW'(eff_slots)) begin
      head_adv = '0;
    end
  end

  // Send byte evaluation
  logic        seen_zero, zero_rej, fin, wr_byte, commit;
  logic [1:0]  verd_new, verd;
  logic [16:0] seen_inc;
  status_t     send_status;
  logic [AW-1:0] wr_addr, rd_addr;

  always_comb begin
    seen_zero = (send_bytes_seen == 16'd0);
    zero_rej  = seen_zero && (message_length == 16'd0);
    if (message_length > 16'(eff_max)) begin
      verd_new = ST_BAD_LEN[1:0];
    end else if (is_full) begin
      verd_new = ST_FULL[1:0];
    end else begin
      verd_new = ST_OK[1:0];
    end
    verd     = seen_zero ? verd_new : send_verdict;
    seen_inc = {1'b0, send_bytes_seen} + 17'd1;
    fin      = (seen_inc >= {1'b0, message_length})
            || ((verd == ST_OK[1:0]) && (seen_inc >= 17'(eff_max)))
            || (seen_inc >= 17'h0FFFF);
    wr_byte  = cmd.accept_send && !zero_rej && (verd == ST_OK[1:0])
            && (send_bytes_seen < 16'(MAX_MESSAGE_BYTES));
    commit   = cmd.accept_send && !zero_rej && fin && (verd == ST_OK[1:0]) && !is_full;
    priority if (zero_rej) begin
      send_status = ST_BAD_LEN;
    end else if (verd != ST_OK[1:0]) begin
      send_status = status_t'({1'b0, verd});
    end else if (is_full) begin
      send_status = ST_FULL;
    end else begin
      send_status = ST_OK;
    end
    wr_addr = AW'(tail_slot) * AW'(MAX_MESSAGE_BYTES) + AW'(send_bytes_seen);
    rd_addr = rx_base + AW'(rx_idx);
  end

  // Memories
  always_ff @(posedge clk) begin
    if (wr_byte) begin
      slot_bytes[wr_addr] <= data_byte;
    end
    byte_rd <= slot_bytes[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      slot_lengths[tail_slot] <= 7'(seen_inc);
    end
    len_rd <= slot_lengths[head_slot];
  end

  // Receive checks on the stored head length
  logic [6:0] head_len;
  assign head_len = (len_rd > 7'(MAX_MESSAGE_BYTES)) ? 7'(MAX_MESSAGE_BYTES) : len_rd;

  always_comb begin
    stat.empty       = (message_count == '0);
    stat.too_small   = rx_dsz < 16'(head_len);
    stat.zero_len    = (head_len == 7'd0);
    stat.stream_last = ((rx_idx + 7'd1) == rx_len);
  end

  assign cfg_ready = 1'b1;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use    <= SLOTS_IN_USE_RST;
      max_bytes       <= MAX_BYTES_RST;
      head_slot       <= '0;
      tail_slot       <= '0;
      message_count   <= '0;
      send_bytes_seen <= '0;
      send_verdict    <= ST_OK[1:0];
      r_valid         <= 1'b0;
    end else begin
      r_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_SLOTS_IN_USE: slots_in_use <= cfg_data[4:0];
          CFG_MAX_BYTES:    max_bytes    <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.accept_send) begin
        if (zero_rej) begin
          r_valid <= 1'b1;
        end else if (fin) begin
          send_bytes_seen <= '0;
          send_verdict    <= ST_OK[1:0];
          r_valid         <= 1'b1;
        end else begin
          send_bytes_seen <= seen_inc[15:0];
          send_verdict    <= verd;
        end
      end
      if (commit) begin
        tail_slot     <= tail_adv;
        message_count <= message_count + CW'(1);
      end
      if (cmd.rx_fail_empty || cmd.rx_fail_small || cmd.rx_zero || cmd.rx_issue) begin
        r_valid <= 1'b1;
      end
      if (cmd.rx_begin || cmd.rx_zero) begin
        head_slot     <= head_adv;
        message_count <= message_count - CW'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept_send) begin
      r_status   <= send_status;
      r_is_rx    <= 1'b0;
      r_len      <= 7'd0;
      r_last     <= 1'b1;
      r_from_mem <= 1'b0;
    end
    if (cmd.accept_rx) begin
      rx_dsz <= destination_size;
    end
    if (cmd.rx_fail_empty || cmd.rx_fail_small || cmd.rx_zero) begin
      r_status   <= cmd.rx_fail_empty ? ST_EMPTY : (cmd.rx_fail_small ? ST_SMALL : ST_OK);
      r_is_rx    <= 1'b1;
      r_len      <= 7'd0;
      r_last     <= 1'b1;
      r_from_mem <= 1'b0;
    end
    if (cmd.rx_begin) begin
      rx_base <= AW'(head_slot) * AW'(MAX_MESSAGE_BYTES);
      rx_len  <= head_len;
      rx_idx  <= 7'd0;
    end
    if (cmd.rx_issue) begin
      rx_idx     <= rx_idx + 7'd1;
      r_status   <= ST_OK;
      r_is_rx    <= 1'b1;
      r_len      <= rx_len;
      r_last     <= stat.stream_last;
      r_from_mem <= 1'b1;
    end
  end

  assign done            = r_valid;
  assign status          = r_status;
  assign is_receive      = r_is_rx;
  assign out_byte        = r_from_mem ? byte_rd : 8'd0;
  assign received_length = r_len;
  assign last            = r_last;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    message_count <= CW'(SLOTS))
    else $error("message count above slot total");

  a_send_ok_commits: assert property (@(posedge clk) disable iff (rst)
    (r_valid && !r_is_rx && (r_status == ST_OK)) |->
      (message_count == $past(message_count) + CW'(1)))
    else $error("send reported ok without committing a message");

  a_stream_ok: assert property (@(posedge clk) disable iff (rst)
    (r_valid && r_from_mem) |-> (r_status == ST_OK) && (r_len != 7'd0))
    else $error("streamed byte with bad status or zero length");

  a_issue_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.rx_begin |=> (message_count == $past(message_count) - CW'(1)))
    else $error("receive start did not free a slot");
`endif

endmodule

// ===== hw/rtl/variable_length_message_ring_queue.sv =====
// Top level of the message ring queue: controller plus datapath.
//
// A FIFO of whole messages kept in fixed slots of MAX_MESSAGE_BYTES bytes
// each, with a stored length per slot. A request is taken on a clock edge
// where start is high and busy is low. A send delivers one byte per request
// (operation = 0) and is never busy, so send bytes go in one per cycle while
// no receive holds busy high; the first byte of a message is checked for zero
// length, length above the limit, or a full ring, and one status result
// follows only the final byte, in the cycle after it is taken. A receive
// (operation = 1) holds busy high until its final result shows: the slot
// length table is read as the receive is taken, the next cycle checks it
// (an error or a zero length ends the receive there), then one byte per
// cycle of the head message is read through the byte memory's read port.
// Results show on done for exactly one cycle each and cannot be stalled;
// received bytes start once the length check passes, and the last one
// (marked by last) appears in the cycle in which busy drops. A receive may
// come between bytes of a send; the partial send then resumes. Config
// writes (cfg_ready is always high) should only happen while the block is
// idle. No clearing pass runs after reset: slot contents are never used before they are written.
module variable_length_message_ring_queue
  import vlmrq_pkg::*;
#(
  parameter int SLOTS             = SLOTS_DEF,
  parameter int MAX_MESSAGE_BYTES = MAX_BYTES_DEF
)
(
  input  logic        clk,
  input  logic        rst,
  // request
  input  logic        start,
  output logic        busy,
  input  logic        operation,
  input  logic [7:0]  data_byte,
  input  logic [15:0] message_length,
  input  logic [15:0] destination_size,
  // results
  output logic        done,
  output logic [2:0]  status,
  output logic        is_receive,
  output logic [7:0]  out_byte,
  output logic [6:0]  received_length,
  output logic        last,
  // config write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);

  cmd_t     cmd;   // controller commands
  dp_stat_t stat;  // datapath status flags

  vlmrq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  vlmrq_dp #(
    .SLOTS             (SLOTS),
    .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .data_byte        (data_byte),
    .message_length   (message_length),
    .destination_size (destination_size),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .done             (done),
    .status           (status),
    .is_receive       (is_receive),
    .out_byte         (out_byte),
    .received_length  (received_length),
    .last             (last)
  );

endmodule
